[sv/ids_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ids_pkg: shared types and constants of the IR distance scanner
// Register indexes, command codes, field widths and the structs that travel
// between the front end, the back end and the linearizer.
// ----------------------------------------------------------------------------
package ids_pkg;

    // Table depth and converter resolution
    localparam int SENSOR_SLOTS = 8;
    localparam int SAMPLE_BITS  = 12;

    // Fixed field widths
    localparam int ADC_W   = 12;
    localparam int MASK_W  = 8;
    localparam int DIST_W  = 8;
    localparam int CH_W    = 3;
    localparam int GAIN_W  = 24;
    localparam int CNT_W   = 4;
    localparam int PROD_W  = ADC_W + GAIN_W;
    localparam int CHK_W   = PROD_W + DIST_W;
    localparam int REM_W   = 25;
    localparam int STEP_W  = 3;
    localparam int ADDR_W  = 3;

    // Only the low bits of a sample that the converter really delivers count
    localparam int SAMPLE_USE_W = (SAMPLE_BITS < ADC_W) ? SAMPLE_BITS : ADC_W;
    localparam logic [ADC_W-1:0] SAMPLE_MASK = ADC_W'((1 << SAMPLE_USE_W) - 1);

    // Slots a query can look at: mask is eight bits wide
    localparam int QUERY_SLOTS = (SENSOR_SLOTS < MASK_W) ? SENSOR_SLOTS : MASK_W;

    // 1.0 in Q24
    localparam logic [REM_W-1:0] ONE_Q24 = REM_W'(1) << 24;

    // Register indexes
    localparam logic [ADDR_W-1:0] REG_GAIN      = 3'd0;
    localparam logic [ADDR_W-1:0] REG_OFFSET    = 3'd1;
    localparam logic [ADDR_W-1:0] REG_MIN_DIST  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_MAX_DIST  = 3'd3;
    localparam logic [ADDR_W-1:0] REG_CHANNELS  = 3'd4;
    localparam logic [ADDR_W-1:0] REG_THRESHOLD = 3'd5;

    // Command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_QUERY  = 1'b1;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_q24;
        logic [GAIN_W-1:0] offset_q24;
        logic [DIST_W-1:0] min_distance;
        logic [DIST_W-1:0] max_distance;
        logic [CNT_W-1:0]  channels_in_use;
        logic [DIST_W-1:0] obstacle_threshold;
    } ids_cfg_t;

    typedef struct packed {
        logic              cmd;
        logic [ADC_W-1:0]  adc_sample;
        logic [MASK_W-1:0] sensor_mask;
    } ids_item_t;

    typedef struct packed {
        logic              obstacle;
        logic [CH_W-1:0]   next_channel;
        logic [CH_W-1:0]   written_channel;
        logic [DIST_W-1:0] distance_cm;
    } ids_result_t;

endpackage
`default_nettype wire

[sv/ir_distance_scanner_unit.sv]
`default_nettype none
// Path: a sample goes from acceptance to m_tvalid through the queue, the linearizer
//   (with an 8-step restoring divider that out-of-range distances skip), the result
//   and output registers; a query goes through the queue, result and output registers.
// Flow: the back end handles one item at a time and holds on output back-pressure;
//   a two-entry queue keeps s_tready up meanwhile until it fills.
// Reset: aresetn is synchronous and active low; it restores register defaults,
//   clears the distance table and sets the scan back to channel 0.
// ----------------------------------------------------------------------------
// ir_distance_scanner_unit: round-robin IR rangefinder linearizer
// Converts sensor samples to distances in cm, stores them per channel and
// answers obstacle queries over a sensor mask.
// ----------------------------------------------------------------------------
module ir_distance_scanner_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [23:0] cfg_wdata,
    // Input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [11:0] adc_sample, [19:12] sensor_mask, [23:20] zero
    input  wire logic [0:0]  s_tuser,   // [0] cmd
    // Result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata    // [7:0] distance_cm, [10:8] written_channel,
                                        // [13:11] next_channel, [14] obstacle, [15] zero
);

    ids_pkg::ids_cfg_t    cfg_reg;
    ids_pkg::ids_item_t   in_item;
    ids_pkg::ids_item_t   head_item;
    ids_pkg::ids_result_t out_result;
    logic                 head_valid;
    logic                 head_pop;

    // Configuration registers; writes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_q24           <= 24'd9770;
            cfg_reg.offset_q24         <= 24'd167772;
            cfg_reg.min_distance       <= 8'd10;
            cfg_reg.max_distance       <= 8'd80;
            cfg_reg.channels_in_use    <= 4'd7;
            cfg_reg.obstacle_threshold <= 8'd20;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                ids_pkg::REG_GAIN:      cfg_reg.gain_q24           <= cfg_wdata;
                ids_pkg::REG_OFFSET:    cfg_reg.offset_q24         <= cfg_wdata;
                ids_pkg::REG_MIN_DIST:  cfg_reg.min_distance       <= cfg_wdata[7:0];
                ids_pkg::REG_MAX_DIST:  cfg_reg.max_distance       <= cfg_wdata[7:0];
                ids_pkg::REG_CHANNELS:  cfg_reg.channels_in_use    <= cfg_wdata[3:0];
                ids_pkg::REG_THRESHOLD: cfg_reg.obstacle_threshold <= cfg_wdata[7:0];
                default: begin
                end
            endcase
        end
    end

    // Unpack the input transaction
    assign in_item.cmd         = s_tuser[0];
    assign in_item.adc_sample  = s_tdata[11:0];
    assign in_item.sensor_mask = s_tdata[19:12];

    // Front end: accept and queue
    ids_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_pop   (head_pop)
    );

    // Back end: execute, keep the table, hold the result transaction
    ids_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .head_pop   (head_pop),
        .out_valid  (m_tvalid),
        .out_result (out_result),
        .out_ready  (m_tready)
    );

    // Pack the result transaction
    assign m_tdata = {1'b0, out_result.obstacle, out_result.next_channel,
                      out_result.written_channel, out_result.distance_cm};

endmodule
`default_nettype wire

[sv/ids_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ids_front: input acceptance and item queue
// Accepts stream transactions and holds them in
// a two-entry queue that the back end drains at its own pace.
// ----------------------------------------------------------------------------
module ids_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ids_pkg::ids_item_t in_item,
    output logic                    head_valid,
    output ids_pkg::ids_item_t      head_item,
    input  wire logic               head_pop
);

    ids_pkg::ids_item_t queue_reg [2];
    logic               wr_ptr_reg;
    logic               rd_ptr_reg;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               push;
    logic               pop;

    assign in_ready   = (count_reg != 2'd2);
    assign push       = in_valid && in_ready;
    assign head_valid = (count_reg != 2'd0);
    assign pop        = head_pop && head_valid;
    assign head_item  = queue_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
        end
    end

    // Payload storage needs no reset
    always_ff @(posedge aclk) begin
        if (push) begin
            queue_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

[sv/ids_linearizer.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ids_linearizer: sample to distance conversion
// Forms D = sample * gain - offset, checks the bounds by multiplication and,
// when in range, runs an eight-step restoring division of 2^24 by D.
// ----------------------------------------------------------------------------
module ids_linearizer (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire ids_pkg::ids_cfg_t            cfg,
    input  wire logic                         start,
    input  wire logic [ids_pkg::ADC_W-1:0]    sample,
    output logic                              done,
    output logic [ids_pkg::DIST_W-1:0]        distance
);

    typedef enum logic [2:0] {
        L_IDLE,
        L_MUL,
        L_SUB,
        L_CMUL,
        L_CHK,
        L_DIV,
        L_DONE
    } lin_state_t;

    lin_state_t                       state_reg;
    logic [ids_pkg::ADC_W-1:0]        sample_reg;
    logic [ids_pkg::PROD_W-1:0]       prod_reg;
    logic [ids_pkg::PROD_W-1:0]       d_reg;
    logic                             pos_reg;
    logic [ids_pkg::CHK_W-1:0]        lo_reg;
    logic [ids_pkg::CHK_W-1:0]        hi_reg;
    logic [ids_pkg::REM_W-1:0]        rem_reg;
    logic [ids_pkg::REM_W-1:0]        rem_next;
    logic [ids_pkg::DIST_W-1:0]       q_reg;
    logic [ids_pkg::DIST_W-1:0]       q_next;
    logic [ids_pkg::STEP_W-1:0]       step_reg;
    logic [ids_pkg::CHK_W-1:0]        one_wide;
    logic [ids_pkg::CHK_W-1:0]        trial;
    logic [ids_pkg::CHK_W-1:0]        rem_wide;
    logic                             in_range;

    assign done     = (state_reg == L_DONE);
    assign distance = q_reg;

    assign one_wide = ids_pkg::CHK_W'(ids_pkg::ONE_Q24);
    // Quotient is valid when min <= 2^24/D <= max, tested exactly
    assign in_range = pos_reg && !(lo_reg > one_wide) && !(hi_reg < one_wide);

    // One restoring step: quotient bit step_reg
    always_comb begin
        trial    = ids_pkg::CHK_W'(d_reg) << step_reg;
        rem_wide = ids_pkg::CHK_W'(rem_reg);
        rem_next = rem_reg;
        q_next   = q_reg;
        if (trial <= rem_wide) begin
            rem_next         = ids_pkg::REM_W'(rem_wide - trial);
            q_next[step_reg] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= L_IDLE;
        end else begin
            unique case (state_reg)
                L_IDLE: begin
                    if (start) begin
                        sample_reg <= sample;
                        state_reg  <= L_MUL;
                    end
                end
                L_MUL: begin
                    prod_reg  <= ids_pkg::PROD_W'(sample_reg) *
                                 ids_pkg::PROD_W'(cfg.gain_q24);
                    state_reg <= L_SUB;
                end
                L_SUB: begin
                    pos_reg   <= (prod_reg > ids_pkg::PROD_W'(cfg.offset_q24));
                    d_reg     <= prod_reg - ids_pkg::PROD_W'(cfg.offset_q24);
                    state_reg <= L_CMUL;
                end
                L_CMUL: begin
                    lo_reg    <= ids_pkg::CHK_W'(cfg.min_distance) * ids_pkg::CHK_W'(d_reg);
                    hi_reg    <= ids_pkg::CHK_W'(cfg.max_distance) * ids_pkg::CHK_W'(d_reg);
                    state_reg <= L_CHK;
                end
                L_CHK: begin
                    // In range means the quotient is at most max, so eight bits hold it
                    q_reg    <= '0;
                    rem_reg  <= ids_pkg::ONE_Q24;
                    step_reg <= ids_pkg::STEP_W'(ids_pkg::DIST_W - 1);
                    if (in_range) begin
                        state_reg <= L_DIV;
                    end else begin
                        state_reg <= L_DONE;
                    end
                end
                L_DIV: begin
                    rem_reg  <= rem_next;
                    q_reg    <= q_next;
                    step_reg <= step_reg - ids_pkg::STEP_W'(1);
                    if (step_reg == '0) begin
                        state_reg <= L_DONE;
                    end
                end
                L_DONE: begin
                    state_reg <= L_IDLE;
                end
                default: begin
                    state_reg <= L_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[sv/ids_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ids_back: item execution and result register
// Pops queued items, runs samples through the linearizer, keeps the distance
// table and scan channel, answers queries and holds the output transaction.
// ----------------------------------------------------------------------------
module ids_back (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire ids_pkg::ids_cfg_t    cfg,
    input  wire logic                 head_valid,
    input  wire ids_pkg::ids_item_t   head_item,
    output logic                      head_pop,
    output logic                      out_valid,
    output ids_pkg::ids_result_t      out_result,
    input  wire logic                 out_ready
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_LIN,
        S_OUT
    } back_state_t;

    back_state_t                  state_reg;
    logic [ids_pkg::DIST_W-1:0]   dist_tab_reg [ids_pkg::SENSOR_SLOTS];
    logic [ids_pkg::CH_W-1:0]     current_reg;
    ids_pkg::ids_result_t         res_reg;
    ids_pkg::ids_result_t         out_reg;
    logic                         out_valid_reg;
    logic                         lin_start;
    logic                         lin_done;
    logic [ids_pkg::DIST_W-1:0]   lin_dist;
    logic                         hit;
    logic [ids_pkg::CNT_W:0]      count_eff;
    logic [ids_pkg::CNT_W:0]      inc;
    logic [ids_pkg::CH_W-1:0]     current_next;

    assign head_pop   = (state_reg == S_IDLE) && head_valid;
    assign lin_start  = head_pop && (head_item.cmd == ids_pkg::CMD_SAMPLE);
    assign out_valid  = out_valid_reg;
    assign out_result = out_reg;

    ids_linearizer u_lin (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .start    (lin_start),
        .sample   (head_item.adc_sample & ids_pkg::SAMPLE_MASK),
        .done     (lin_done),
        .distance (lin_dist)
    );

    // Obstacle test over the masked slots
    always_comb begin
        hit = 1'b0;
        for (int i = 0; i < ids_pkg::QUERY_SLOTS; i++) begin
            if (head_item.sensor_mask[i] && (dist_tab_reg[i] != '0) &&
                (dist_tab_reg[i] < cfg.obstacle_threshold)) begin
                hit = 1'b1;
            end
        end
    end

    // Clamp the channel count and advance the scan
    always_comb begin
        count_eff = {1'b0, cfg.channels_in_use};
        if (count_eff == '0) begin
            count_eff = (ids_pkg::CNT_W+1)'(1);
        end
        if (count_eff > (ids_pkg::CNT_W+1)'(ids_pkg::SENSOR_SLOTS)) begin
            count_eff = (ids_pkg::CNT_W+1)'(ids_pkg::SENSOR_SLOTS);
        end
        inc = (ids_pkg::CNT_W+1)'(current_reg) + (ids_pkg::CNT_W+1)'(1);
        if (inc >= count_eff) begin
            current_next = '0;
        end else begin
            current_next = inc[ids_pkg::CH_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            current_reg   <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < ids_pkg::SENSOR_SLOTS; i++) begin
                dist_tab_reg[i] <= '0;
            end
        end else begin
            // Drop the taken output unless a new result replaces it
            if (out_valid_reg && out_ready && (state_reg != S_OUT)) begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (head_valid) begin
                        if (head_item.cmd == ids_pkg::CMD_QUERY) begin
                            res_reg.distance_cm     <= '0;
                            res_reg.written_channel <= '0;
                            res_reg.next_channel    <= current_reg;
                            res_reg.obstacle        <= hit;
                            state_reg               <= S_OUT;
                        end else begin
                            state_reg <= S_LIN;
                        end
                    end
                end
                S_LIN: begin
                    if (lin_done) begin
                        for (int i = 0; i < ids_pkg::SENSOR_SLOTS; i++) begin
                            if (int'(current_reg) == i) begin
                                dist_tab_reg[i] <= lin_dist;
                            end
                        end
                        current_reg             <= current_next;
                        res_reg.distance_cm     <= lin_dist;
                        res_reg.written_channel <= current_reg;
                        res_reg.next_channel    <= current_next;
                        res_reg.obstacle        <= 1'b0;
                        state_reg               <= S_OUT;
                    end
                end
                S_OUT: begin
                    // Load the output register once it is free or being drained
                    if (!out_valid_reg || out_ready) begin
                        out_reg       <= res_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[verif/ir_distance_scanner_unit_tb.sv]
// ----------------------------------------------------------------------------
// ir_distance_scanner_unit_tb: self-checking bench for the IR distance scanner
// Streams sample and query transactions into the scanner under random
// back-pressure and source gaps. It predicts every result from its own copy
// of the registers, the distance table and the scan channel, and compares the
// results field by field as they leave. Register settings change between
// phases, only while the scanner is idle.
// ----------------------------------------------------------------------------
module ir_distance_scanner_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    // Indexes past the register map; writes to them must change nothing
    localparam logic [ids_pkg::ADDR_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [ids_pkg::ADDR_W-1:0] REG_SPARE_HI = 3'd7;

    localparam longint unsigned UNITY_Q24   = 64'd1 << 24;
    localparam int              CYCLE_LIMIT = 400000;
    localparam int              DRAIN_WAIT  = 30;

    // ------------------------------------------------------------------
    // Clock, reset and block ports
    // ------------------------------------------------------------------
    logic              aclk      = 1'b0;
    logic              aresetn   = 1'b0;
    logic              cfg_we    = 1'b0;
    logic [2:0]        cfg_addr  = '0;
    logic [23:0]       cfg_wdata = '0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [23:0]       s_tdata   = '0;   // [11:0] adc_sample, [19:12] sensor_mask
    logic [0:0]        s_tuser   = '0;   // [0] cmd
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [15:0]       m_tdata;          // [7:0] distance_cm, [10:8] written_channel,
                                         // [13:11] next_channel, [14] obstacle

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    ir_distance_scanner_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // ------------------------------------------------------------------
    // Scanner shadow: registers, distance table and scan position
    // ------------------------------------------------------------------
    ids_pkg::ids_cfg_t          cfg_shadow;
    logic [ids_pkg::DIST_W-1:0] range_table [ids_pkg::SENSOR_SLOTS];
    logic [ids_pkg::CH_W-1:0]   scan_channel;

    ids_pkg::ids_item_t   scan_requests [$];    // transactions waiting to be driven
    ids_pkg::ids_result_t expected_reports [$]; // predictions waiting for their result
    ids_pkg::ids_item_t   item_on_bus;
    logic              item_taken    = 1'b0;
    int                items_queued  = 0;
    int                items_taken   = 0;
    int                mismatch_count = 0;
    int                cycle_count   = 0;
    int                src_gap       = 0;
    int                sink_stall    = 0;
    bit                no_idle       = 1'b0;

    // Reciprocal linearization: exact bound tests first, then truncate
    function automatic logic [ids_pkg::DIST_W-1:0] linearize_cm(
        logic [ids_pkg::ADC_W-1:0] sample);
        longint unsigned prod;
        longint unsigned recip;
        prod = 64'(sample & ids_pkg::SAMPLE_MASK) * 64'(cfg_shadow.gain_q24);
        if (prod <= 64'(cfg_shadow.offset_q24))
            return '0;
        recip = prod - 64'(cfg_shadow.offset_q24);
        // quotient below the minimum distance
        if (UNITY_Q24 < 64'(cfg_shadow.min_distance) * recip)
            return '0;
        // quotient above the maximum distance
        if (UNITY_Q24 > 64'(cfg_shadow.max_distance) * recip)
            return '0;
        return ids_pkg::DIST_W'(UNITY_Q24 / recip);
    endfunction

    // Advance the shadow by one accepted transaction and return its result
    function automatic ids_pkg::ids_result_t predict_scan(ids_pkg::ids_item_t it);
        ids_pkg::ids_result_t res;
        int          count;
        int          nxt;
        res = '0;
        if (it.cmd == ids_pkg::CMD_SAMPLE) begin
            // clamp the channel count to 1..SENSOR_SLOTS
            count = int'(cfg_shadow.channels_in_use);
            if (count == 0)
                count = 1;
            if (count > ids_pkg::SENSOR_SLOTS)
                count = ids_pkg::SENSOR_SLOTS;
            res.distance_cm     = linearize_cm(it.adc_sample);
            res.written_channel = scan_channel;
            range_table[int'(scan_channel) % ids_pkg::SENSOR_SLOTS] = res.distance_cm;
            // wrap whenever the next channel reaches the count, even from beyond it
            nxt = int'(scan_channel) + 1;
            if (nxt >= count)
                nxt = 0;
            scan_channel     = ids_pkg::CH_W'(nxt);
            res.next_channel = scan_channel;
        end else begin
            res.next_channel = scan_channel;
            for (int i = 0; i < ids_pkg::QUERY_SLOTS; i++) begin
                if (it.sensor_mask[i] && range_table[i] != '0 &&
                    range_table[i] < cfg_shadow.obstacle_threshold)
                    res.obstacle = 1'b1;
            end
        end
        return res;
    endfunction

    // Mostly short gaps, a few long ones, none during a steady stretch
    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random transaction; most samples aim at the valid distance window
    function automatic ids_pkg::ids_item_t make_item();
        ids_pkg::ids_item_t it;
        longint unsigned target;
        longint unsigned want_sample;
        int              lo;
        int              hi;
        it.cmd         = ids_pkg::CMD_SAMPLE;
        it.adc_sample  = ids_pkg::ADC_W'($urandom);
        it.sensor_mask = ids_pkg::MASK_W'($urandom);
        if ($urandom_range(0, 99) < 25) begin
            it.cmd = ids_pkg::CMD_QUERY;
            if ($urandom_range(0, 4) == 0)
                it.sensor_mask = '1;
            return it;
        end
        lo = (cfg_shadow.min_distance == 0) ? 1 : int'(cfg_shadow.min_distance);
        hi = int'(cfg_shadow.max_distance);
        if (cfg_shadow.gain_q24 != 0 && hi >= lo && $urandom_range(0, 9) < 7) begin
            target      = 64'($urandom_range(lo, hi));
            want_sample = (UNITY_Q24 / target + 64'(cfg_shadow.offset_q24)) /
                          64'(cfg_shadow.gain_q24);
            // nudge across the bound by one code now and then
            want_sample = want_sample + 64'($urandom_range(0, 2));
            want_sample = (want_sample == 0) ? 0 : want_sample - 1;
            if (want_sample > 64'(4095))
                want_sample = 64'(4095);
            it.adc_sample = ids_pkg::ADC_W'(want_sample);
        end
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Reporting
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what, int want, int got);
        $display("[%0t] MISMATCH %s: expected %0d, got %0d", $realtime, what, want, got);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // Source driver: change inputs at the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !item_taken) begin
            // hold the transaction until the scanner takes it
        end else if (src_gap > 0) begin
            s_tvalid <= 1'b0;
            src_gap--;
        end else if (scan_requests.size() > 0) begin
            item_on_bus = scan_requests.pop_front();
            s_tdata  <= {4'b0, item_on_bus.sensor_mask, item_on_bus.adc_sample};
            s_tuser  <= item_on_bus.cmd;
            s_tvalid <= 1'b1;
            src_gap  = pick_gap();
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // Record acceptance and predict its result at the rising edge
    always @(posedge aclk) begin
        item_taken <= aresetn && s_tvalid && s_tready;
        if (aresetn && s_tvalid && s_tready) begin
            expected_reports.push_back(predict_scan(item_on_bus));
            items_taken++;
        end
    end

    // ------------------------------------------------------------------
    // Result monitor: stall at random, check at the rising edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (sink_stall > 0) begin
            m_tready <= 1'b0;
            sink_stall--;
        end else begin
            m_tready   <= 1'b1;
            sink_stall = pick_gap();
        end
    end

    always @(posedge aclk) begin
        ids_pkg::ids_result_t got;
        ids_pkg::ids_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = ids_pkg::ids_result_t'(m_tdata[14:0]);
            if (expected_reports.size() == 0) begin
                report_mismatch("unexpected result, distance_cm", -1, int'(got.distance_cm));
            end else begin
                want = expected_reports.pop_front();
                if (got.distance_cm != want.distance_cm)
                    report_mismatch("distance_cm", want.distance_cm, got.distance_cm);
                if (got.written_channel != want.written_channel)
                    report_mismatch("written_channel", want.written_channel,
                                    got.written_channel);
                if (got.next_channel != want.next_channel)
                    report_mismatch("next_channel", want.next_channel, got.next_channel);
                if (got.obstacle != want.obstacle)
                    report_mismatch("obstacle", want.obstacle, got.obstacle);
            end
        end
    end

    // Watchdog; also switch idling on and off in stretches
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count % 256 == 0)
            no_idle = ($urandom_range(0, 3) == 0);
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[%0t] timeout with %0d results outstanding", $realtime,
                     expected_reports.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------
    task automatic queue_item(logic cmd, logic [ids_pkg::ADC_W-1:0] sample,
                              logic [ids_pkg::MASK_W-1:0] mask);
        ids_pkg::ids_item_t it;
        it.cmd         = cmd;
        it.adc_sample  = sample;
        it.sensor_mask = mask;
        scan_requests.push_back(it);
        items_queued++;
    endtask

    task automatic queue_random(int count);
        repeat (count) begin
            scan_requests.push_back(make_item());
            items_queued++;
        end
    endtask

    // Wait until every transaction is taken and every result has come back
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (items_taken != items_queued || expected_reports.size() != 0);
    endtask

    // Write one register and mirror it in the shadow
    task automatic write_reg(logic [ids_pkg::ADDR_W-1:0] idx, logic [23:0] val);
        @(negedge aclk);
        cfg_we    = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = val;
        case (idx)
            ids_pkg::REG_GAIN:      cfg_shadow.gain_q24           = val;
            ids_pkg::REG_OFFSET:    cfg_shadow.offset_q24         = val;
            ids_pkg::REG_MIN_DIST:  cfg_shadow.min_distance       = val[ids_pkg::DIST_W-1:0];
            ids_pkg::REG_MAX_DIST:  cfg_shadow.max_distance       = val[ids_pkg::DIST_W-1:0];
            ids_pkg::REG_CHANNELS:  cfg_shadow.channels_in_use    = val[ids_pkg::CNT_W-1:0];
            ids_pkg::REG_THRESHOLD: cfg_shadow.obstacle_threshold = val[ids_pkg::DIST_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_we = 1'b0;
    endtask

    task automatic configure(logic [23:0] gain, logic [23:0] offset, logic [23:0] min_cm,
                             logic [23:0] max_cm, logic [23:0] chans, logic [23:0] thresh);
        write_reg(ids_pkg::REG_GAIN, gain);
        write_reg(ids_pkg::REG_OFFSET, offset);
        write_reg(ids_pkg::REG_MIN_DIST, min_cm);
        write_reg(ids_pkg::REG_MAX_DIST, max_cm);
        write_reg(ids_pkg::REG_CHANNELS, chans);
        write_reg(ids_pkg::REG_THRESHOLD, thresh);
    endtask

    initial begin
        logic [23:0] rnd_min;

        // reset defaults of the shadow
        cfg_shadow.gain_q24           = 24'd9770;
        cfg_shadow.offset_q24         = 24'd167772;
        cfg_shadow.min_distance       = 8'd10;
        cfg_shadow.max_distance       = 8'd80;
        cfg_shadow.channels_in_use    = 4'd7;
        cfg_shadow.obstacle_threshold = 8'd20;
        foreach (range_table[i])
            range_table[i] = '0;
        scan_channel = '0;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed, reset settings: zero, below offset, window edges, full scale,
        // channel wrap at a count of seven, and queries over several masks
        queue_item(ids_pkg::CMD_SAMPLE, 12'd0,    8'h00);
        queue_item(ids_pkg::CMD_SAMPLE, 12'd17,   8'h00);
        queue_item(ids_pkg::CMD_SAMPLE, 12'd39,   8'h00);
        queue_item(ids_pkg::CMD_SAMPLE, 12'd189,  8'h00);
        queue_item(ids_pkg::CMD_SAMPLE, 12'd188,  8'h00);
        queue_item(ids_pkg::CMD_SAMPLE, 12'd4095, 8'hFF);
        queue_item(ids_pkg::CMD_QUERY,  12'hFFF,  8'hFF);
        queue_item(ids_pkg::CMD_QUERY,  12'd0,    8'h00);
        queue_item(ids_pkg::CMD_QUERY,  12'd0,    8'hEF);
        queue_item(ids_pkg::CMD_SAMPLE, 12'd100,  8'h00);
        queue_item(ids_pkg::CMD_SAMPLE, 12'd50,   8'h00);
        queue_item(ids_pkg::CMD_QUERY,  12'd0,    8'h80);
        wait_drained();

        // Directed, exact bounds: gain of 2^20 puts 2^24/D at 16/sample;
        // a channel count of zero keeps every sample in slot 0
        configure(24'h100000, 24'd0, 24'd8, 24'd16, 24'd0, 24'd17);
        queue_item(ids_pkg::CMD_SAMPLE, 12'd1, 8'h00);
        queue_item(ids_pkg::CMD_QUERY,  12'd0, 8'h01);
        queue_item(ids_pkg::CMD_SAMPLE, 12'd2, 8'h00);
        queue_item(ids_pkg::CMD_QUERY,  12'd0, 8'hFE);
        queue_item(ids_pkg::CMD_QUERY,  12'd0, 8'h01);
        queue_item(ids_pkg::CMD_SAMPLE, 12'd3, 8'h00);
        queue_item(ids_pkg::CMD_QUERY,  12'd0, 8'hFF);
        wait_drained();

        // Random: reset settings
        configure(24'd9770, 24'd167772, 24'd10, 24'd80, 24'd7, 24'd20);
        queue_random(120);
        wait_drained();

        // Random: wide window, all eight channels, spare indexes poked
        configure(24'd100, 24'd0, 24'd0, 24'd255, 24'd8, 24'd255);
        write_reg(REG_SPARE_LO, 24'($urandom));
        write_reg(REG_SPARE_HI, 24'($urandom));
        queue_random(100);
        wait_drained();

        // Random: gain, offset and window at their top values, count and threshold of zero
        configure(24'hFFFFFF, 24'hFFFFFF, 24'd255, 24'd255, 24'd0, 24'd0);
        queue_random(40);
        wait_drained();

        // Random: count above the table size, junk above the count field
        configure(24'd1000, 24'd50000, 24'd1, 24'd200, {20'($urandom), 4'd15}, 24'd100);
        queue_random(100);
        wait_drained();

        // Random settings
        repeat (3) begin
            rnd_min = 24'($urandom_range(0, 40));
            configure(24'($urandom_range(50, 20000)), 24'($urandom_range(0, 500000)),
                      rnd_min, 24'($urandom_range(int'(rnd_min), 255)),
                      24'($urandom), 24'($urandom_range(0, 255)));
            queue_random(80);
            wait_drained();
        end

        // let the pipeline settle before the verdict
        repeat (DRAIN_WAIT) @(negedge aclk);
        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
